/* rtl/aprc_pkg.sv */
// aprc_pkg: shared widths, result codes, pipeline item record and rounding helpers
// for the box pair impulse response core.
// No dependencies; imported by every module of the block.
`default_nettype none

package aprc_pkg;

  // Field formats
  localparam int COMP_W = 21;
  localparam int NCOMP  = 3;
  localparam int VEC_W  = NCOMP * COMP_W;
  localparam int MASS_W = 32;
  localparam int REST_W = 14;
  localparam int CFG_W  = 12;

  // Internal widths
  localparam int DIF_W  = COMP_W + 1;
  localparam int HSUM_W = COMP_W + 1;
  localparam int DEP_W  = COMP_W + 2;
  localparam int SQ_W   = 43;
  localparam int S2_W   = 44;
  localparam int RAD_W  = 62;
  localparam int ROOT_W = 31;
  localparam int MSUM_W = MASS_W + 1;
  localparam int K_W    = 16;
  localparam int NRM_W  = 17;
  localparam int WGT_W  = 17;
  localparam int PROD_W = 39;
  localparam int DOT_W  = 40;
  localparam int VN_W   = 25;
  localparam int KVN_W  = 41;
  localparam int Q_W    = 27;
  localparam int QW_W   = 45;
  localparam int P_W    = 28;
  localparam int T_W    = 45;
  localparam int R_W    = 28;

  // Shifts of the fixed point steps
  localparam int RAD_SHIFT = 18;
  localparam int NRM_SHIFT = 24;
  localparam int NORM_FRAC = 15;
  localparam int K_FRAC    = 13;
  localparam int WGT_FRAC  = 16;

  // Divider lanes: three normal components, then the two mass weights
  localparam int DIV_LANES = 5;
  localparam int DIV_NUM_W = 50;
  localparam int DIV_DEN_W = 33;
  localparam int DIV_QUO_W = 17;
  localparam int LANE_WA   = 3;
  localparam int LANE_WB   = 4;

  localparam logic [MASS_W-1:0] MASS_FLOOR = 32'd7;
  localparam logic [MASS_W-1:0] MASS_ONE   = 32'd65536;
  localparam logic [K_W-1:0]    K_ONE      = 16'd8192;
  localparam logic [CFG_W-1:0]  DEPTH_RST  = 12'd4;

  typedef enum logic [1:0] {
    OUT_APPLIED    = 2'd0,
    OUT_NO_OVERLAP = 2'd1,
    OUT_SHALLOW    = 2'd2,
    OUT_COINCIDE   = 2'd3
  } outcome_e;

  // One item as it moves down the pipeline; each stage fills in its fields
  typedef struct packed {
    outcome_e                                  outcome;
    logic [NCOMP-1:0][DIF_W-1:0]               d;
    logic [NCOMP-1:0][HSUM_W-1:0]              h;
    logic [NCOMP-1:0][COMP_W-1:0]              va;
    logic [NCOMP-1:0][COMP_W-1:0]              vb;
    logic [MASS_W-1:0]                         ma;
    logic [MASS_W-1:0]                         mb;
    logic [MSUM_W-1:0]                         msum;
    logic [K_W-1:0]                            k;
    logic [NCOMP-1:0][SQ_W-1:0]                sq;
    logic [S2_W-1:0]                           s2;
    logic [ROOT_W-1:0]                         len;
    logic [DIV_LANES-1:0][DIV_NUM_W-1:0]       num;
    logic [DIV_LANES-1:0][DIV_DEN_W-1:0]       den;
    logic [NCOMP-1:0][NRM_W-1:0]               n;
    logic [WGT_W-1:0]                          wa;
    logic [WGT_W-1:0]                          wb;
    logic [NCOMP-1:0][PROD_W-1:0]              prod;
    logic [DOT_W-1:0]                          dot;
    logic [VN_W-1:0]                           vn;
    logic [KVN_W-1:0]                          kvn;
    logic [Q_W-1:0]                            q;
    logic [QW_W-1:0]                           qa;
    logic [QW_W-1:0]                           qb;
    logic [P_W-1:0]                            pa;
    logic [P_W-1:0]                            pb;
    logic [NCOMP-1:0][T_W-1:0]                 ta;
    logic [NCOMP-1:0][T_W-1:0]                 tb;
    logic [NCOMP-1:0][R_W-1:0]                 ra;
    logic [NCOMP-1:0][R_W-1:0]                 rb;
    logic [NCOMP-1:0][COMP_W-1:0]              nva;
    logic [NCOMP-1:0][COMP_W-1:0]              nvb;
  } pipe_t;

  // round(v / 2^s), ties away from zero
  function automatic logic signed [63:0] shr_round(input logic signed [63:0] v, input int s);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (s - 1))) >> s;
    return v[63] ? $signed(-m) : $signed(m);
  endfunction

  // clamp to one signed component
  function automatic logic [COMP_W-1:0] sat_comp(input logic signed [63:0] v);
    logic [COMP_W-1:0] r;
    if (v > 64'sd1048575) begin
      r = 21'h0FFFFF;
    end else if (v < -64'sd1048576) begin
      r = 21'h100000;
    end else begin
      r = v[COMP_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/aabb_pair_impulse_response_core.sv */
// aabb_pair_impulse_response_core: overlap test and impulse response for one
// box pair per cycle. Depends on aprc_pkg, aprc_isqrt and aprc_div.
//
//  channel | handshake               | payload
//  --------+-------------------------+-------------------------------------------
//  in      | in_valid_i / in_ready_o | a_*_i, b_*_i centers, extents, velocities,
//          |                         | masses, restitutions
//  out     | out_valid_o/out_ready_i | new_a_velocity_o, new_b_velocity_o, outcome_o
//  cfg     | cfg_valid_i/cfg_ready_o | cfg_data_i (min_overlap_depth)
//
// One pair accepted per cycle while the output is not stalled. Stages: 3 front stages, 31 square
// root stages, 1 stage forming dividends, 17 divider stages, 10 back stages.
// The square root and divider chains set the depth.
// Reset clears all valid bits and sets min_overlap_depth to 4.
// A stalled output freezes the whole pipeline; the output register holds the
// item until taken, and the input is held off for as long as the stall lasts.
`default_nettype none

module aabb_pair_impulse_response_core
  import aprc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [CFG_W-1:0]  cfg_data_i,
  // pair in
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [VEC_W-1:0]  a_center_i,
  input  wire logic [VEC_W-1:0]  a_half_extent_i,
  input  wire logic [VEC_W-1:0]  a_velocity_i,
  input  wire logic [VEC_W-1:0]  b_center_i,
  input  wire logic [VEC_W-1:0]  b_half_extent_i,
  input  wire logic [VEC_W-1:0]  b_velocity_i,
  input  wire logic [MASS_W-1:0] a_mass_i,
  input  wire logic [MASS_W-1:0] b_mass_i,
  input  wire logic [REST_W-1:0] a_restitution_i,
  input  wire logic [REST_W-1:0] b_restitution_i,
  // result out
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [VEC_W-1:0]       new_a_velocity_o,
  output logic [VEC_W-1:0]       new_b_velocity_o,
  output logic [1:0]             outcome_o
);

  localparam int PIPE_W = $bits(pipe_t);
  localparam int NST    = 14;
  // stage slots
  localparam int ST_A = 0;
  localparam int ST_B = 1;
  localparam int ST_C = 2;
  localparam int ST_D = 3;
  localparam int ST_E = 4;
  localparam int ST_F = 5;
  localparam int ST_G = 6;
  localparam int ST_H = 7;
  localparam int ST_I = 8;
  localparam int ST_J = 9;
  localparam int ST_K = 10;
  localparam int ST_L = 11;
  localparam int ST_M = 12;
  localparam int ST_N = 13;

  logic [CFG_W-1:0] min_depth_q;
  logic             en;
  pipe_t            st_d [NST];
  pipe_t            st_q [NST];
  logic [NST-1:0]   vld_d, vld_q;

  logic              sqrt_vld;
  logic [ROOT_W-1:0] sqrt_root;
  logic [PIPE_W-1:0] sqrt_side;
  logic              div_vld;
  logic [DIV_LANES-1:0][DIV_QUO_W-1:0] div_quo;
  logic [PIPE_W-1:0] div_side;

  // global advance: the output register is free or being drained
  assign en          = !vld_q[ST_N] || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_depth_q <= DEPTH_RST;
    end else if (cfg_valid_i) begin
      min_depth_q <= cfg_data_i;
    end
  end

  // A: differences, extent sums, effective masses, 1+e
  always_comb begin
    st_d[ST_A] = '0;
    for (int i = 0; i < NCOMP; i++) begin
      st_d[ST_A].d[i]  = DIF_W'($signed(b_center_i[i*COMP_W +: COMP_W]))
                       - DIF_W'($signed(a_center_i[i*COMP_W +: COMP_W]));
      st_d[ST_A].h[i]  = HSUM_W'(a_half_extent_i[i*COMP_W +: COMP_W])
                       + HSUM_W'(b_half_extent_i[i*COMP_W +: COMP_W]);
      st_d[ST_A].va[i] = a_velocity_i[i*COMP_W +: COMP_W];
      st_d[ST_A].vb[i] = b_velocity_i[i*COMP_W +: COMP_W];
    end
    st_d[ST_A].ma = (a_mass_i < MASS_FLOOR) ? MASS_ONE : a_mass_i;
    st_d[ST_A].mb = (b_mass_i < MASS_FLOOR) ? MASS_ONE : b_mass_i;
    st_d[ST_A].k  = K_ONE + K_W'(a_restitution_i) + K_W'(b_restitution_i);
  end

  // B: depths and outcome, squares, mass sum
  always_comb begin
    logic [DIF_W-1:0]          ad;
    logic signed [DEP_W-1:0]   dep;
    logic signed [DEP_W-1:0]   dmin;
    logic signed [2*DIF_W-1:0] p;
    logic                      ovl;
    logic                      coin;
    st_d[ST_B] = st_q[ST_A];
    dmin = '0;
    ovl  = 1'b1;
    coin = 1'b1;
    for (int i = 0; i < NCOMP; i++) begin
      ad  = st_q[ST_A].d[i][DIF_W-1] ? DIF_W'(-$signed(st_q[ST_A].d[i])) : st_q[ST_A].d[i];
      dep = $signed(DEP_W'(st_q[ST_A].h[i])) - $signed(DEP_W'(ad));
      if (dep < 0) ovl = 1'b0;
      if (st_q[ST_A].d[i] != '0) coin = 1'b0;
      if (i == 0 || dep < dmin) dmin = dep;
      p = $signed(st_q[ST_A].d[i]) * $signed(st_q[ST_A].d[i]);
      st_d[ST_B].sq[i] = SQ_W'(p);
    end
    st_d[ST_B].msum = MSUM_W'(st_q[ST_A].ma) + MSUM_W'(st_q[ST_A].mb);
    if (!ovl) begin
      st_d[ST_B].outcome = OUT_NO_OVERLAP;
    end else if (coin) begin
      st_d[ST_B].outcome = OUT_COINCIDE;
    end else if (dmin < $signed(DEP_W'(min_depth_q))) begin
      st_d[ST_B].outcome = OUT_SHALLOW;
    end else begin
      st_d[ST_B].outcome = OUT_APPLIED;
    end
  end

  // C: squared length
  always_comb begin
    st_d[ST_C]    = st_q[ST_B];
    st_d[ST_C].s2 = S2_W'(st_q[ST_B].sq[0]) + S2_W'(st_q[ST_B].sq[1])
                  + S2_W'(st_q[ST_B].sq[2]);
  end

  // length, scaled by 2^9
  aprc_isqrt #(
    .SIDE_W (PIPE_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld_q[ST_C]),
    .rad_i   (RAD_W'(st_q[ST_C].s2) << RAD_SHIFT),
    .side_i  (PIPE_W'(st_q[ST_C])),
    .valid_o (sqrt_vld),
    .root_o  (sqrt_root),
    .side_o  (sqrt_side)
  );

  // D: rounded dividends for the normal and the mass weights
  always_comb begin
    logic [DIF_W-1:0] ad;
    st_d[ST_D]     = pipe_t'(sqrt_side);
    st_d[ST_D].len = sqrt_root;
    for (int i = 0; i < NCOMP; i++) begin
      ad = st_d[ST_D].d[i][DIF_W-1] ? DIF_W'(-$signed(st_d[ST_D].d[i])) : st_d[ST_D].d[i];
      st_d[ST_D].num[i] = (DIV_NUM_W'(ad) << NRM_SHIFT) + DIV_NUM_W'(sqrt_root >> 1);
      st_d[ST_D].den[i] = DIV_DEN_W'(sqrt_root);
    end
    st_d[ST_D].num[LANE_WA] = (DIV_NUM_W'(st_d[ST_D].mb) << WGT_FRAC)
                            + DIV_NUM_W'(st_d[ST_D].msum >> 1);
    st_d[ST_D].den[LANE_WA] = st_d[ST_D].msum;
    st_d[ST_D].num[LANE_WB] = (DIV_NUM_W'(st_d[ST_D].ma) << WGT_FRAC)
                            + DIV_NUM_W'(st_d[ST_D].msum >> 1);
    st_d[ST_D].den[LANE_WB] = st_d[ST_D].msum;
  end

  aprc_div #(
    .LANES  (DIV_LANES),
    .NUM_W  (DIV_NUM_W),
    .DEN_W  (DIV_DEN_W),
    .QUO_W  (DIV_QUO_W),
    .SIDE_W (PIPE_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld_q[ST_D]),
    .num_i   (st_q[ST_D].num),
    .den_i   (st_q[ST_D].den),
    .side_i  (PIPE_W'(st_q[ST_D])),
    .valid_o (div_vld),
    .quo_o   (div_quo),
    .side_o  (div_side)
  );

  // E: signed normal, weights, relative velocity times normal
  always_comb begin
    logic signed [NRM_W-1:0]  ni;
    logic signed [DIF_W-1:0]  dv;
    logic signed [PROD_W-1:0] pr;
    st_d[ST_E]    = pipe_t'(div_side);
    st_d[ST_E].wa = WGT_W'(div_quo[LANE_WA]);
    st_d[ST_E].wb = WGT_W'(div_quo[LANE_WB]);
    for (int i = 0; i < NCOMP; i++) begin
      ni = st_d[ST_E].d[i][DIF_W-1] ? -$signed(NRM_W'(div_quo[i])) : $signed(NRM_W'(div_quo[i]));
      dv = DIF_W'($signed(st_d[ST_E].va[i])) - DIF_W'($signed(st_d[ST_E].vb[i]));
      pr = dv * ni;
      st_d[ST_E].n[i]    = ni;
      st_d[ST_E].prod[i] = pr;
    end
  end

  // F: dot product
  always_comb begin
    st_d[ST_F]     = st_q[ST_E];
    st_d[ST_F].dot = DOT_W'($signed(st_q[ST_E].prod[0])) + DOT_W'($signed(st_q[ST_E].prod[1]))
                   + DOT_W'($signed(st_q[ST_E].prod[2]));
  end

  // G: normal velocity
  always_comb begin
    st_d[ST_G]    = st_q[ST_F];
    st_d[ST_G].vn = VN_W'(shr_round(64'($signed(st_q[ST_F].dot)), NORM_FRAC));
  end

  // H: (1+e) * vn
  always_comb begin
    logic signed [KVN_W-1:0] kv;
    st_d[ST_H]     = st_q[ST_G];
    kv             = $signed({1'b0, st_q[ST_G].k}) * $signed(st_q[ST_G].vn);
    st_d[ST_H].kvn = kv;
  end

  // I: impulse numerator
  always_comb begin
    st_d[ST_I]   = st_q[ST_H];
    st_d[ST_I].q = Q_W'(shr_round(64'($signed(st_q[ST_H].kvn)), K_FRAC));
  end

  // J: impulse times weights
  always_comb begin
    logic signed [QW_W-1:0] pa_w, pb_w;
    st_d[ST_J]    = st_q[ST_I];
    pa_w          = $signed(st_q[ST_I].q) * $signed({1'b0, st_q[ST_I].wa});
    pb_w          = $signed(st_q[ST_I].q) * $signed({1'b0, st_q[ST_I].wb});
    st_d[ST_J].qa = pa_w;
    st_d[ST_J].qb = pb_w;
  end

  // K: per-box impulse
  always_comb begin
    st_d[ST_K]    = st_q[ST_J];
    st_d[ST_K].pa = P_W'(shr_round(64'($signed(st_q[ST_J].qa)), WGT_FRAC));
    st_d[ST_K].pb = P_W'(shr_round(64'($signed(st_q[ST_J].qb)), WGT_FRAC));
  end

  // L: impulse along the normal
  always_comb begin
    logic signed [T_W-1:0] tap, tbp;
    st_d[ST_L] = st_q[ST_K];
    for (int i = 0; i < NCOMP; i++) begin
      tap = $signed(st_q[ST_K].pa) * $signed(st_q[ST_K].n[i]);
      tbp = $signed(st_q[ST_K].pb) * $signed(st_q[ST_K].n[i]);
      st_d[ST_L].ta[i] = tap;
      st_d[ST_L].tb[i] = tbp;
    end
  end

  // M: velocity changes
  always_comb begin
    st_d[ST_M] = st_q[ST_L];
    for (int i = 0; i < NCOMP; i++) begin
      st_d[ST_M].ra[i] = R_W'(shr_round(64'($signed(st_q[ST_L].ta[i])), NORM_FRAC));
      st_d[ST_M].rb[i] = R_W'(shr_round(64'($signed(st_q[ST_L].tb[i])), NORM_FRAC));
    end
  end

  // N: apply and saturate, or pass the velocities through for a skipped pair
  always_comb begin
    st_d[ST_N] = st_q[ST_M];
    for (int i = 0; i < NCOMP; i++) begin
      if (st_q[ST_M].outcome == OUT_APPLIED) begin
        st_d[ST_N].nva[i] = sat_comp(64'($signed(st_q[ST_M].va[i]))
                                     - 64'($signed(st_q[ST_M].ra[i])));
        st_d[ST_N].nvb[i] = sat_comp(64'($signed(st_q[ST_M].vb[i]))
                                     + 64'($signed(st_q[ST_M].rb[i])));
      end else begin
        st_d[ST_N].nva[i] = st_q[ST_M].va[i];
        st_d[ST_N].nvb[i] = st_q[ST_M].vb[i];
      end
    end
  end

  // valid bits travelling with the stages
  always_comb begin
    vld_d       = {vld_q[NST-2:0], in_valid_i};
    vld_d[ST_D] = sqrt_vld;
    vld_d[ST_E] = div_vld;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < NST; s++) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  // result
  assign out_valid_o      = vld_q[ST_N];
  assign new_a_velocity_o = st_q[ST_N].nva;
  assign new_b_velocity_o = st_q[ST_N].nvb;
  assign outcome_o        = st_q[ST_N].outcome;

`ifndef SYNTHESIS
  // a stall freezes every slot
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline slots moved during a stall");

  // an applied pair has a non-zero length
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[ST_N] && st_q[ST_N].outcome == OUT_APPLIED) |-> (st_q[ST_N].len != '0))
    else $error("applied pair with zero length");

  // rounded weights add up to one within a count
  a_weight_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[ST_N] && st_q[ST_N].outcome == OUT_APPLIED) |->
      ((18'(st_q[ST_N].wa) + 18'(st_q[ST_N].wb) == 18'd65535) ||
       (18'(st_q[ST_N].wa) + 18'(st_q[ST_N].wb) == 18'd65536) ||
       (18'(st_q[ST_N].wa) + 18'(st_q[ST_N].wb) == 18'd65537)))
    else $error("mass weights do not sum to one");

  // normal components stay within unit range
  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[ST_N] && st_q[ST_N].outcome == OUT_APPLIED) |->
      (($signed(st_q[ST_N].n[0]) <= 17'sd32768) && ($signed(st_q[ST_N].n[0]) >= -17'sd32768) &&
       ($signed(st_q[ST_N].n[1]) <= 17'sd32768) && ($signed(st_q[ST_N].n[1]) >= -17'sd32768) &&
       ($signed(st_q[ST_N].n[2]) <= 17'sd32768) && ($signed(st_q[ST_N].n[2]) >= -17'sd32768)))
    else $error("normal component out of range");
`endif

endmodule

`default_nettype wire

/* rtl/aprc_isqrt.sv */
// aprc_isqrt: pipelined integer square root, one result bit per stage,
// with an item record carried alongside. Depends on aprc_pkg.
`default_nettype none

module aprc_isqrt
  import aprc_pkg::*;
#(
  parameter int SIDE_W = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [RAD_W-1:0]  rad_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic [ROOT_W-1:0]      root_o,
  output logic [SIDE_W-1:0]      side_o
);

  localparam int NSTEP = ROOT_W;

  logic [RAD_W-1:0]  x_q [NSTEP-1];
  logic [RAD_W-1:0]  r_q [NSTEP];
  logic [SIDE_W-1:0] s_q [NSTEP];
  logic [NSTEP-1:0]  v_q;

  for (genvar g = 0; g < NSTEP; g++) begin : g_step
    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (NSTEP - 1 - g));
    logic [RAD_W-1:0]  x_in, r_in, x_nx, r_nx, trial;
    logic [SIDE_W-1:0] s_in;
    logic              v_in;

    if (g == 0) begin : g_first
      assign x_in = rad_i;
      assign r_in = '0;
      assign s_in = side_i;
      assign v_in = valid_i;
    end else begin : g_next
      assign x_in = x_q[g-1];
      assign r_in = r_q[g-1];
      assign s_in = s_q[g-1];
      assign v_in = v_q[g-1];
    end

    // one digit: subtract when the trial fits
    always_comb begin
      trial = r_in + BIT;
      if (x_in >= trial) begin
        x_nx = x_in - trial;
        r_nx = (r_in >> 1) + BIT;
      end else begin
        x_nx = x_in;
        r_nx = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[g] <= r_nx;
        s_q[g] <= s_in;
      end
    end

    if (g < NSTEP - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[g] <= x_nx;
        end
      end
    end
  end

  assign valid_o = v_q[NSTEP-1];
  assign root_o  = r_q[NSTEP-1][ROOT_W-1:0];
  assign side_o  = s_q[NSTEP-1];

endmodule

`default_nettype wire

/* rtl/aprc_div.sv */
// aprc_div: pipelined restoring divider, several lanes side by side, one
// quotient bit per stage, item record carried alongside. Depends on aprc_pkg.
`default_nettype none

module aprc_div
  import aprc_pkg::*;
#(
  parameter int LANES  = 5,
  parameter int NUM_W  = 50,
  parameter int DEN_W  = 33,
  parameter int QUO_W  = 17,
  parameter int SIDE_W = 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire logic [LANES-1:0][NUM_W-1:0]  num_i,
  input  wire logic [LANES-1:0][DEN_W-1:0]  den_i,
  input  wire logic [SIDE_W-1:0]            side_i,
  output logic                              valid_o,
  output logic [LANES-1:0][QUO_W-1:0]       quo_o,
  output logic [SIDE_W-1:0]                 side_o
);

  logic [LANES-1:0][NUM_W-1:0] rem_q [QUO_W-1];
  logic [LANES-1:0][DEN_W-1:0] den_q [QUO_W-1];
  logic [LANES-1:0][QUO_W-1:0] quo_q [QUO_W];
  logic [SIDE_W-1:0]           s_q   [QUO_W];
  logic [QUO_W-1:0]            v_q;

  for (genvar g = 0; g < QUO_W; g++) begin : g_step
    localparam int B = QUO_W - 1 - g;
    logic [LANES-1:0][NUM_W-1:0] rem_in, rem_nx;
    logic [LANES-1:0][DEN_W-1:0] den_in;
    logic [LANES-1:0][QUO_W-1:0] quo_in, quo_nx;
    logic [SIDE_W-1:0]           s_in;
    logic                        v_in;
    logic [NUM_W-1:0]            shd;

    if (g == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
      assign s_in   = side_i;
      assign v_in   = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign den_in = den_q[g-1];
      assign quo_in = quo_q[g-1];
      assign s_in   = s_q[g-1];
      assign v_in   = v_q[g-1];
    end

    // compare and subtract the shifted divisor in every lane
    always_comb begin
      rem_nx = rem_in;
      quo_nx = quo_in;
      shd    = '0;
      for (int l = 0; l < LANES; l++) begin
        shd = NUM_W'(den_in[l]) << B;
        if (rem_in[l] >= shd) begin
          rem_nx[l]    = rem_in[l] - shd;
          quo_nx[l][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[g] <= quo_nx;
        s_q[g]   <= s_in;
      end
    end

    if (g < QUO_W - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[g] <= rem_nx;
          den_q[g] <= den_in;
        end
      end
    end
  end

  assign valid_o = v_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];
  assign side_o  = s_q[QUO_W-1];

endmodule

`default_nettype wire
